>>> design/mcsb_pkg.sv
// shared types, port codes and defaults for the multicore shared bus and sync ports unit
package mcsb_pkg;

    // default parameter values
    localparam int CORES_DEF        = 8;
    localparam int SHARED_START_DEF = 49152;

    // configuration register indexes and reset values
    localparam logic       CFG_GROUP_SIZE     = 1'b0;
    localparam logic       CFG_BARRIER_TARGET = 1'b1;
    localparam logic [7:0] GROUP_SIZE_RST     = 8'd8;
    localparam logic [3:0] BARRIER_TARGET_RST = 4'd8;

    // operation codes
    localparam logic [1:0] OP_MEM_READ  = 2'd0;
    localparam logic [1:0] OP_MEM_WRITE = 2'd1;
    localparam logic [1:0] OP_PORT_IN   = 2'd2;
    localparam logic [1:0] OP_PORT_OUT  = 2'd3;

    // i/o port numbers
    localparam logic [7:0] PORT_ID      = 8'h01;
    localparam logic [7:0] PORT_SIZE    = 8'h02;
    localparam logic [7:0] PORT_LOCK    = 8'h03;
    localparam logic [7:0] PORT_UNLOCK  = 8'h04;
    localparam logic [7:0] PORT_DONE    = 8'h08;
    localparam logic [7:0] PORT_BARRIER = 8'h09;
    localparam logic [7:0] PORT_READY   = 8'h0A;
    localparam logic [7:0] PORT_RESULT  = 8'h0B;

    // input beat
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  core_id;
        logic [15:0] address;
        logic [7:0]  port_number;
        logic [7:0]  write_value;
    } t_in;

    // result beat
    typedef struct packed {
        logic [7:0]  read_data;
        logic [31:0] shared_reads;
        logic [31:0] shared_writes;
        logic [31:0] contention_ticks;
        logic [31:0] lock_acquisitions;
        logic [31:0] lock_spin_count;
        logic [3:0]  barrier_arrivals;
        logic        core_ready_flag;
        logic        core_halted_flag;
        logic [7:0]  core_reported_value;
        logic [7:0]  core_generic_out;
    } t_out;

endpackage

>>> design/mcsb_ram.sv
// generic single-port synchronous ram with registered read
module mcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write or read one entry; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mcsb_sync.sv
// bus owner, counters, lock, barrier and per-core port state
module mcsb_sync #(
    parameter int NCORE  = 8,
    localparam int CORE_W = (NCORE > 1) ? $clog2(NCORE) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_op,
    input  logic [CORE_W-1:0] i_core,
    input  logic [2:0]        i_id,
    input  logic              i_shared,
    input  logic [7:0]        i_port,
    input  logic [7:0]        i_wval,
    input  logic [7:0]        i_group_size,
    input  logic [3:0]        i_barrier_target,
    output mcsb_pkg::t_out    o_res
);

    logic              r_owner_valid, n_owner_valid;
    logic [CORE_W-1:0] r_owner, n_owner;
    logic              r_lock_busy, n_lock_busy;
    logic [CORE_W-1:0] r_lock_holder, n_lock_holder;
    logic [31:0]       r_reads, n_reads;
    logic [31:0]       r_writes, n_writes;
    logic [31:0]       r_contention, n_contention;
    logic [31:0]       r_acquire, n_acquire;
    logic [31:0]       r_spin, n_spin;
    logic [3:0]        r_arrivals, n_arrivals;
    logic [NCORE-1:0]  r_arrived, n_arrived;
    logic [NCORE-1:0]  r_ready, n_ready;
    logic [NCORE-1:0]  r_halted, n_halted;
    logic [7:0]        r_reported [NCORE];
    logic [7:0]        n_reported [NCORE];
    logic [7:0]        r_generic [NCORE];
    logic [7:0]        n_generic [NCORE];
    logic [7:0]        port_rd;

    // next state and port read data for the presented access
    always_comb begin
        n_owner_valid = r_owner_valid;
        n_owner       = r_owner;
        n_lock_busy   = r_lock_busy;
        n_lock_holder = r_lock_holder;
        n_reads       = r_reads;
        n_writes      = r_writes;
        n_contention  = r_contention;
        n_acquire     = r_acquire;
        n_spin        = r_spin;
        n_arrivals    = r_arrivals;
        n_arrived     = r_arrived;
        n_ready       = r_ready;
        n_halted      = r_halted;
        n_reported    = r_reported;
        n_generic     = r_generic;
        port_rd       = 8'd0;
        case (i_op)
            mcsb_pkg::OP_MEM_READ, mcsb_pkg::OP_MEM_WRITE: begin
                if (i_shared) begin
                    if (i_op == mcsb_pkg::OP_MEM_READ) begin
                        n_reads = r_reads + 32'd1;
                    end else begin
                        n_writes = r_writes + 32'd1;
                    end
                    // ownership change counts a contention tick
                    if (!r_owner_valid || (r_owner != i_core)) begin
                        n_contention  = r_contention + 32'd1;
                        n_owner_valid = 1'b1;
                        n_owner       = i_core;
                    end
                end
            end
            mcsb_pkg::OP_PORT_IN: begin
                case (i_port)
                    mcsb_pkg::PORT_SIZE: begin
                        port_rd = i_group_size;
                    end
                    mcsb_pkg::PORT_LOCK: begin
                        if (!r_lock_busy) begin
                            n_lock_busy   = 1'b1;
                            n_lock_holder = i_core;
                            n_acquire     = r_acquire + 32'd1;
                        end else begin
                            n_spin  = r_spin + 32'd1;
                            port_rd = 8'd1;
                        end
                    end
                    mcsb_pkg::PORT_BARRIER: begin
                        if (!r_arrived[i_core]) begin
                            n_arrived[i_core] = 1'b1;
                            n_arrivals        = r_arrivals + 4'd1;
                        end
                        port_rd = {7'd0, (n_arrivals >= i_barrier_target)};
                    end
                    default: begin
                        // id port and unknown ports return the raw id
                        port_rd = {5'd0, i_id};
                    end
                endcase
            end
            mcsb_pkg::OP_PORT_OUT: begin
                case (i_port)
                    mcsb_pkg::PORT_UNLOCK: begin
                        if (r_lock_busy && (r_lock_holder == i_core)) begin
                            n_lock_busy = 1'b0;
                        end
                    end
                    mcsb_pkg::PORT_READY: begin
                        n_ready[i_core] = 1'b1;
                    end
                    mcsb_pkg::PORT_RESULT: begin
                        n_reported[i_core] = i_wval;
                    end
                    mcsb_pkg::PORT_DONE: begin
                        n_halted[i_core] = 1'b1;
                    end
                    default: begin
                        n_generic[i_core] = i_wval;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // result fields as seen after this access
    always_comb begin
        o_res.read_data           = port_rd;
        o_res.shared_reads        = n_reads;
        o_res.shared_writes       = n_writes;
        o_res.contention_ticks    = n_contention;
        o_res.lock_acquisitions   = n_acquire;
        o_res.lock_spin_count     = n_spin;
        o_res.barrier_arrivals    = n_arrivals;
        o_res.core_ready_flag     = n_ready[i_core];
        o_res.core_halted_flag    = n_halted[i_core];
        o_res.core_reported_value = n_reported[i_core];
        o_res.core_generic_out    = n_generic[i_core];
    end

    // state update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_valid <= 1'b0;
            r_owner       <= '0;
            r_lock_busy   <= 1'b0;
            r_lock_holder <= '0;
            r_reads       <= '0;
            r_writes      <= '0;
            r_contention  <= '0;
            r_acquire     <= '0;
            r_spin        <= '0;
            r_arrivals    <= '0;
            r_arrived     <= '0;
            r_ready       <= '0;
            r_halted      <= '0;
            for (int k = 0; k < NCORE; k++) begin
                r_reported[k] <= '0;
                r_generic[k]  <= '0;
            end
        end else if (i_fire) begin
            r_owner_valid <= n_owner_valid;
            r_owner       <= n_owner;
            r_lock_busy   <= n_lock_busy;
            r_lock_holder <= n_lock_holder;
            r_reads       <= n_reads;
            r_writes      <= n_writes;
            r_contention  <= n_contention;
            r_acquire     <= n_acquire;
            r_spin        <= n_spin;
            r_arrivals    <= n_arrivals;
            r_arrived     <= n_arrived;
            r_ready       <= n_ready;
            r_halted      <= n_halted;
            r_reported    <= n_reported;
            r_generic     <= n_generic;
        end
    end

endmodule

>>> design/multicore_shared_bus_and_sync_ports_unit.sv
// top level of the multicore shared bus and sync ports unit
//
//  channel   direction  handshake             payload
//  in        input      i_in_valid/o_in_stall  i_in_data  (mcsb_pkg::t_in)
//  out       output     o_out_valid/i_out_stall o_out_data (mcsb_pkg::t_out)
//  cfg       input      i_cfg_we              i_cfg_index, i_cfg_data
//
// one beat per cycle sustained while the output does not stall; a result passes from its
// accepted beat through the ram stage (ram read), then the output register
// the single-port ram read latency sets the stage between accept and result
// reset clears counters, flags, lock and bus owner at once; ram contents stay as they were
// a stalled output holds the middle stage, and the input stalls only while both are full
module multicore_shared_bus_and_sync_ports_unit #(
    parameter int CORES        = mcsb_pkg::CORES_DEF,
    parameter int SHARED_START = mcsb_pkg::SHARED_START_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mcsb_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mcsb_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [7:0]     i_cfg_data
);

    // only ids 0..7 exist, so at most eight cores hold state
    localparam int NCORE      = (CORES < 8) ? CORES : 8;
    localparam int CORE_W     = (NCORE > 1) ? $clog2(NCORE) : 1;
    localparam int PRIV_DEPTH = NCORE * SHARED_START;
    localparam int PRIV_AW    = (PRIV_DEPTH > 1) ? $clog2(PRIV_DEPTH) : 1;
    localparam int SH_DEPTH   = 65536 - SHARED_START;
    localparam int SH_AW      = (SH_DEPTH > 1) ? $clog2(SH_DEPTH) : 1;

    typedef struct packed {
        mcsb_pkg::t_out res;
        logic           ram_rd;
        logic           ram_shared;
    } t_s1;

    logic [7:0]        r_group_size;
    logic [3:0]        r_barrier_target;
    logic              r_s1_valid;
    t_s1               r_s1;
    logic              r_out_valid;
    mcsb_pkg::t_out    r_out;

    logic              fire;
    logic              s1_adv;
    logic [7:0]        core_mod;
    logic [CORE_W-1:0] core;
    logic              is_mem;
    logic              is_shared;
    logic              is_write;
    logic [PRIV_AW-1:0] priv_addr;
    logic [SH_AW-1:0]  sh_addr;
    logic [7:0]        priv_q;
    logic [7:0]        sh_q;
    mcsb_pkg::t_out    sync_res;
    mcsb_pkg::t_out    s1_res;

    // handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !(!r_out_valid || !i_out_stall);
    assign fire       = i_in_valid && !o_in_stall;

    // core index: id reduced modulo the core count
    always_comb begin
        core_mod = {5'd0, i_in_data.core_id};
        for (int k = 0; k < 7; k++) begin
            if (core_mod >= 8'(CORES)) begin
                core_mod = core_mod - 8'(CORES);
            end
        end
    end
    assign core = CORE_W'(core_mod);

    // address decode
    assign is_mem    = (i_in_data.op == mcsb_pkg::OP_MEM_READ) ||
                       (i_in_data.op == mcsb_pkg::OP_MEM_WRITE);
    assign is_write  = (i_in_data.op == mcsb_pkg::OP_MEM_WRITE);
    assign is_shared = (i_in_data.address >= 16'(SHARED_START));
    assign priv_addr = PRIV_AW'(32'(core) * 32'(SHARED_START)) + PRIV_AW'(i_in_data.address);
    assign sh_addr   = SH_AW'(i_in_data.address - 16'(SHARED_START));

    mcsb_ram #(
        .WIDTH (8),
        .DEPTH (PRIV_DEPTH)
    ) u_priv_ram (
        .i_clk   (i_clk),
        .i_en    (fire && is_mem && !is_shared),
        .i_we    (is_write),
        .i_addr  (priv_addr),
        .i_wdata (i_in_data.write_value),
        .o_rdata (priv_q)
    );

    mcsb_ram #(
        .WIDTH (8),
        .DEPTH (SH_DEPTH)
    ) u_sh_ram (
        .i_clk   (i_clk),
        .i_en    (fire && is_mem && is_shared),
        .i_we    (is_write),
        .i_addr  (sh_addr),
        .i_wdata (i_in_data.write_value),
        .o_rdata (sh_q)
    );

    mcsb_sync #(
        .NCORE (NCORE)
    ) u_sync (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_op             (i_in_data.op),
        .i_core           (core),
        .i_id             (i_in_data.core_id),
        .i_shared         (is_shared),
        .i_port           (i_in_data.port_number),
        .i_wval           (i_in_data.write_value),
        .i_group_size     (r_group_size),
        .i_barrier_target (r_barrier_target),
        .o_res            (sync_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size     <= mcsb_pkg::GROUP_SIZE_RST;
            r_barrier_target <= mcsb_pkg::BARRIER_TARGET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mcsb_pkg::CFG_GROUP_SIZE:     r_group_size     <= i_cfg_data;
                mcsb_pkg::CFG_BARRIER_TARGET: r_barrier_target <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // merge ram read data into the result
    always_comb begin
        s1_res = r_s1.res;
        if (r_s1.ram_rd) begin
            s1_res.read_data = r_s1.ram_shared ? sh_q : priv_q;
        end
    end

    // stage and output valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage and output payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1.res        <= sync_res;
            r_s1.ram_rd     <= is_mem && !is_write;
            r_s1.ram_shared <= is_shared;
        end
        if (s1_adv) begin
            r_out <= s1_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // input stalls only while the ram stage is occupied
    a_stall_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty ram stage");

    // an accepted beat occupies the ram stage next cycle
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_s1_valid)
        else $error("accepted beat lost before ram stage");

    // a beat leaving the ram stage shows up at the output
    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_out_valid)
        else $error("ram stage result not presented");
`endif

endmodule
